// ===== hw/rtl/bmcc_pkg.sv =====
package bmcc_pkg;

    localparam int TIME_W = 32;
    localparam int NOW_W  = 32;
    localparam int CFG_W  = 20;
    localparam int IDX_W  = 3;
    localparam int CMP_W  = (TIME_W > CFG_W) ? TIME_W : CFG_W;

    typedef logic [TIME_W-1:0] t_time;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_HOLD_MS      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_STUCK_MS     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FLASH_ON_MS  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FLASH_OFF_MS = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FLASH_PULSES = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FLASH_ENABLE = 3'd5;

    // register reset values
    localparam logic [15:0] RST_HOLD_MS      = 16'd300;
    localparam logic [19:0] RST_STUCK_MS     = 20'd10000;
    localparam logic [15:0] RST_FLASH_ON_MS  = 16'd100;
    localparam logic [15:0] RST_FLASH_OFF_MS = 16'd100;
    localparam logic [3:0]  RST_FLASH_PULSES = 4'd3;
    localparam logic        RST_FLASH_ENABLE = 1'b1;

    // motor cut machine
    localparam logic [1:0] CUT_RELEASED = 2'd0;
    localparam logic [1:0] CUT_CUT      = 2'd1;
    localparam logic [1:0] CUT_HOLD     = 2'd2;

    // flash machine
    localparam logic [1:0] FL_IDLE  = 2'd0;
    localparam logic [1:0] FL_ON    = 2'd1;
    localparam logic [1:0] FL_OFF   = 2'd2;
    localparam logic [1:0] FL_SOLID = 2'd3;

    typedef struct packed {
        logic braking;
        logic motor_cut;
        logic ever_braked;
        logic brake_stuck;
        logic flash_blank;
    } t_result;

    function automatic t_time elapsed(input t_time now, input t_time since);
        elapsed = now - since;
    endfunction

    // elapsed >= limit, both zero-extended to a common width
    function automatic logic time_ge(input t_time el, input logic [CFG_W-1:0] lim);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = CMP_W'(el);
        b = CMP_W'(lim);
        time_ge = (a >= b);
    endfunction

endpackage

// ===== hw/rtl/bmcc_if.sv =====
interface bmcc_in_if;
    import bmcc_pkg::*;

    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             brake_front;
    logic             brake_rear;

    modport source (output valid, output now_ms, output brake_front, output brake_rear,
                    input ready);
    modport sink   (input valid, input now_ms, input brake_front, input brake_rear,
                    output ready);
endinterface

interface bmcc_out_if;
    logic valid;
    logic ready;
    logic braking;
    logic motor_cut;
    logic ever_braked;
    logic brake_stuck;
    logic flash_blank;

    modport source (output valid, output braking, output motor_cut, output ever_braked,
                    output brake_stuck, output flash_blank, input ready);
    modport sink   (input valid, input braking, input motor_cut, input ever_braked,
                    input brake_stuck, input flash_blank, output ready);
endinterface

interface bmcc_cfg_if;
    import bmcc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/brake_motor_cut_controller_top.sv =====
// Brake / motor-cut controller. Each input beat is one update tick (ms timestamp plus
// front and rear lever levels) and yields exactly one result beat, computed in the
// same cycle the beat is taken and held in an output register backed by a one-entry
// skid stage. One beat per cycle is sustained while the output is not stalled. The input
// stalls only when both the output and skid registers are full. Configuration writes
// are always accepted (ready held high); unknown indexes are ignored. Elapsed times
// wrap modulo 2^TIME_W.
module brake_motor_cut_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmcc_in_if.sink    i_in,
    bmcc_cfg_if.sink   i_cfg,
    bmcc_out_if.source o_out
);
    import bmcc_pkg::*;

    // configuration
    logic [15:0] r_hold_ms;
    logic [19:0] r_stuck_ms;
    logic [15:0] r_flash_on_ms;
    logic [15:0] r_flash_off_ms;
    logic [3:0]  r_flash_pulses;
    logic        r_flash_enable;

    // tick state
    logic [1:0] r_cut_mode,    n_cut_mode;
    t_time      r_hold_start,  n_hold_start;
    t_time      r_brake_start, n_brake_start;
    logic       r_was_braking;
    logic       r_ever,        n_ever;
    logic [1:0] r_flash_mode,  n_flash_mode;
    logic [3:0] r_pulses_left, n_pulses_left;
    t_time      r_flash_start, n_flash_start;

    // output register and skid
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    t_time   now;
    logic    braking;
    logic    onset;
    logic    in_fire;
    logic    stall;
    t_result res;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign stall       = r_out_valid && !o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms      <= RST_HOLD_MS;
            r_stuck_ms     <= RST_STUCK_MS;
            r_flash_on_ms  <= RST_FLASH_ON_MS;
            r_flash_off_ms <= RST_FLASH_OFF_MS;
            r_flash_pulses <= RST_FLASH_PULSES;
            r_flash_enable <= RST_FLASH_ENABLE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HOLD_MS:      r_hold_ms      <= i_cfg.data[15:0];
                CFG_STUCK_MS:     r_stuck_ms     <= i_cfg.data[19:0];
                CFG_FLASH_ON_MS:  r_flash_on_ms  <= i_cfg.data[15:0];
                CFG_FLASH_OFF_MS: r_flash_off_ms <= i_cfg.data[15:0];
                CFG_FLASH_PULSES: r_flash_pulses <= i_cfg.data[3:0];
                CFG_FLASH_ENABLE: r_flash_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        now     = t_time'(i_in.now_ms);
        braking = i_in.brake_front || i_in.brake_rear;
        onset   = braking && !r_was_braking;

        n_brake_start = onset ? now : r_brake_start;
        n_ever        = r_ever || onset;

        n_flash_mode  = r_flash_mode;
        n_pulses_left = r_pulses_left;
        n_flash_start = r_flash_start;
        if (onset && r_flash_enable) begin
            n_flash_mode  = FL_ON;
            n_pulses_left = r_flash_pulses;
            n_flash_start = now;
        end

        if (!r_flash_enable || !braking) begin
            n_flash_mode = FL_IDLE;
        end else begin
            case (n_flash_mode)
                FL_ON: begin
                    if (time_ge(elapsed(now, n_flash_start), CFG_W'(r_flash_on_ms))) begin
                        n_flash_start = now;
                        n_pulses_left = n_pulses_left - 4'd1;   // 0 wraps to 15
                        n_flash_mode  = (n_pulses_left == 4'd0) ? FL_SOLID : FL_OFF;
                    end
                end
                FL_OFF: begin
                    if (time_ge(elapsed(now, n_flash_start), CFG_W'(r_flash_off_ms))) begin
                        n_flash_start = now;
                        n_flash_mode  = FL_ON;
                    end
                end
                default: ;
            endcase
        end

        n_cut_mode   = r_cut_mode;
        n_hold_start = r_hold_start;
        case (r_cut_mode)
            CUT_CUT: begin
                if (!braking) begin
                    n_cut_mode   = CUT_HOLD;
                    n_hold_start = now;
                end
            end
            CUT_HOLD: begin
                if (braking) begin
                    n_cut_mode = CUT_CUT;
                end else if (time_ge(elapsed(now, r_hold_start), CFG_W'(r_hold_ms))) begin
                    n_cut_mode = CUT_RELEASED;
                end
            end
            default: begin
                n_cut_mode = braking ? CUT_CUT : CUT_RELEASED;
            end
        endcase

        res.braking     = braking;
        res.motor_cut   = (n_cut_mode != CUT_RELEASED);
        res.ever_braked = n_ever;
        res.brake_stuck = braking && time_ge(elapsed(now, n_brake_start), r_stuck_ms);
        res.flash_blank = (n_flash_mode == FL_OFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_mode    <= CUT_RELEASED;
            r_hold_start  <= '0;
            r_brake_start <= '0;
            r_was_braking <= 1'b0;
            r_ever        <= 1'b0;
            r_flash_mode  <= FL_IDLE;
            r_pulses_left <= '0;
            r_flash_start <= '0;
        end else if (in_fire) begin
            r_cut_mode    <= n_cut_mode;
            r_hold_start  <= n_hold_start;
            r_brake_start <= n_brake_start;
            r_was_braking <= braking;
            r_ever        <= n_ever;
            r_flash_mode  <= n_flash_mode;
            r_pulses_left <= n_pulses_left;
            r_flash_start <= n_flash_start;
        end
    end

    // output register with skid: a beat arriving while the output stalls parks in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (stall) begin
            if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stall) begin
            if (in_fire) begin
                r_skid <= res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.braking     = r_out.braking;
    assign o_out.motor_cut   = r_out.motor_cut;
    assign o_out.ever_braked = r_out.ever_braked;
    assign o_out.brake_stuck = r_out.brake_stuck;
    assign o_out.flash_blank = r_out.flash_blank;

endmodule
